// ===== design/wie_pkg.sv =====
// shared types and constants of the wasm i32 stack executor
package wie_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   localparam logic [7:0] OP_UNREACHABLE = 8'h00;
   localparam logic [7:0] OP_NOP         = 8'h01;
   localparam logic [7:0] OP_CONST       = 8'h41;
   localparam logic [7:0] OP_EQZ         = 8'h45;
   localparam logic [7:0] OP_EQ          = 8'h46;
   localparam logic [7:0] OP_NE          = 8'h47;
   localparam logic [7:0] OP_LT_S        = 8'h48;
   localparam logic [7:0] OP_LT_U        = 8'h49;
   localparam logic [7:0] OP_GT_S        = 8'h4A;
   localparam logic [7:0] OP_GT_U        = 8'h4B;
   localparam logic [7:0] OP_LE_S        = 8'h4C;
   localparam logic [7:0] OP_LE_U        = 8'h4D;
   localparam logic [7:0] OP_GE_S        = 8'h4E;
   localparam logic [7:0] OP_GE_U        = 8'h4F;
   localparam logic [7:0] OP_CLZ         = 8'h67;
   localparam logic [7:0] OP_CTZ         = 8'h68;
   localparam logic [7:0] OP_ADD         = 8'h6A;
   localparam logic [7:0] OP_SUB         = 8'h6B;
   localparam logic [7:0] OP_MUL         = 8'h6C;
   localparam logic [7:0] OP_DIV_S       = 8'h6D;
   localparam logic [7:0] OP_DIV_U       = 8'h6E;
   localparam logic [7:0] OP_REM_S       = 8'h6F;
   localparam logic [7:0] OP_REM_U       = 8'h70;
   localparam logic [7:0] OP_AND         = 8'h71;
   localparam logic [7:0] OP_OR          = 8'h72;
   localparam logic [7:0] OP_XOR         = 8'h73;
   localparam logic [7:0] OP_SHL         = 8'h74;
   localparam logic [7:0] OP_SHR_S       = 8'h75;
   localparam logic [7:0] OP_SHR_U       = 8'h76;
   localparam logic [7:0] OP_ROTL        = 8'h77;
   localparam logic [7:0] OP_ROTR        = 8'h78;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FALLBACK = 2'd1;
   localparam logic [1:0] ST_TRAP     = 2'd2;

   localparam logic [1:0] TC_NONE        = 2'd0;
   localparam logic [1:0] TC_UNREACHABLE = 2'd1;
   localparam logic [1:0] TC_DIV_ZERO    = 2'd2;
   localparam logic [1:0] TC_OVERFLOW    = 2'd3;

   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0]         operation;
      logic signed [31:0] immediate;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  trap_cause;
      logic [31:0] stack_top;
      logic [7:0]  depth;
   } rsp_type;

endpackage

// ===== design/wasm_i32_stack_executor.sv =====
// wasm i32 stack executor top level with memory-held operand stack
//
// channel  ports                     direction  handshake
// req      start busy req_data       in         taken when start and not busy
// rsp      rsp_strobe rsp_data       out        one-cycle strobe, no stall
//
// nop, unreachable, const, unary ops, fallbacks: strobe in the next cycle
// binary ops: S_OPER uses the registered read of the second operand
// traps of binary ops: a further read in S_FETCH refetches the new top;
// S_FETCH is skipped when the trap leaves the stack empty
// div and rem: S_DIV waits on the one-bit-per-cycle divider
// reset empties the stack at once; the next item may start while strobe shows
module wasm_i32_stack_executor (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wie_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output wie_pkg::rsp_type  rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_OPER, S_DIV, S_FETCH} state_type;

   localparam int PW = wie_pkg::PTR_W;
   localparam int CW = wie_pkg::CNT_W;

   logic [31:0] stack_mem [wie_pkg::STACK_DEPTH];
   logic [31:0] rd_data_ff;

   state_type   state_ff, state_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [31:0] top_ff, top_in;
   logic [7:0]  op_ff, op_in;
   logic        strobe_ff, strobe_in;
   wie_pkg::rsp_type rsp_ff, rsp_in;
   logic        neg_ff, neg_in;

   logic          mem_we;
   logic [PW-1:0] mem_wa, mem_ra;
   logic [31:0]   mem_wd;

   logic        div_start, div_done;
   logic [31:0] div_a, div_b, div_q, div_r;

   logic [31:0] lhs, rhs, alu, unary, dres;
   logic [4:0]  sh;
   logic        is_bin, is_div;
   logic [5:0]  lead, trail;

   wie_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= stack_mem[mem_ra];
   end

   assign lhs = rd_data_ff;
   assign rhs = top_ff;
   assign sh  = rhs[4:0];

   always_comb begin
      lead = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (top_ff[i]) lead = 6'(31 - i);
      end
      trail = 6'd32;
      for (int i = 31; i >= 0; i--) begin
         if (top_ff[i]) trail = 6'(i);
      end
   end

   always_comb begin
      case (req_data.operation)
         wie_pkg::OP_EQZ: unary = {31'd0, top_ff == 32'd0};
         wie_pkg::OP_CLZ: unary = {26'd0, lead};
         default:         unary = {26'd0, trail};
      endcase
   end

   always_comb begin
      case (op_ff)
         wie_pkg::OP_EQ:    alu = {31'd0, lhs == rhs};
         wie_pkg::OP_NE:    alu = {31'd0, lhs != rhs};
         wie_pkg::OP_LT_S:  alu = {31'd0, $signed(lhs) < $signed(rhs)};
         wie_pkg::OP_LT_U:  alu = {31'd0, lhs < rhs};
         wie_pkg::OP_GT_S:  alu = {31'd0, $signed(lhs) > $signed(rhs)};
         wie_pkg::OP_GT_U:  alu = {31'd0, lhs > rhs};
         wie_pkg::OP_LE_S:  alu = {31'd0, $signed(lhs) <= $signed(rhs)};
         wie_pkg::OP_LE_U:  alu = {31'd0, lhs <= rhs};
         wie_pkg::OP_GE_S:  alu = {31'd0, $signed(lhs) >= $signed(rhs)};
         wie_pkg::OP_GE_U:  alu = {31'd0, lhs >= rhs};
         wie_pkg::OP_ADD:   alu = lhs + rhs;
         wie_pkg::OP_SUB:   alu = lhs - rhs;
         wie_pkg::OP_MUL:   alu = lhs * rhs;
         wie_pkg::OP_AND:   alu = lhs & rhs;
         wie_pkg::OP_OR:    alu = lhs | rhs;
         wie_pkg::OP_XOR:   alu = lhs ^ rhs;
         wie_pkg::OP_SHL:   alu = lhs << sh;
         wie_pkg::OP_SHR_S: alu = 32'($signed(lhs) >>> sh);
         wie_pkg::OP_SHR_U: alu = lhs >> sh;
         wie_pkg::OP_ROTL:  alu = (lhs << sh) | (lhs >> (6'd32 - {1'b0, sh}));
         default:           alu = (lhs >> sh) | (lhs << (6'd32 - {1'b0, sh}));
      endcase
   end

   always_comb begin
      case (req_data.operation) inside
         [wie_pkg::OP_EQ:wie_pkg::OP_GE_U], [wie_pkg::OP_ADD:wie_pkg::OP_ROTR]:
            is_bin = 1'b1;
         default: is_bin = 1'b0;
      endcase
      case (op_ff) inside
         [wie_pkg::OP_DIV_S:wie_pkg::OP_REM_U]: is_div = 1'b1;
         default:                               is_div = 1'b0;
      endcase
   end

   always_comb begin
      if (op_ff == wie_pkg::OP_DIV_S || op_ff == wie_pkg::OP_DIV_U) dres = div_q;
      else dres = div_r;
      if (neg_ff) dres = 32'd0 - dres;
   end

   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      top_in    = top_ff;
      op_in     = op_ff;
      neg_in    = neg_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      mem_we    = 1'b0;
      mem_wa    = PW'(depth_ff);
      mem_wd    = 32'd0;
      mem_ra    = PW'(depth_ff - CW'(2));
      div_start = 1'b0;
      div_a     = lhs;
      div_b     = rhs;

      rsp_in.status     = wie_pkg::ST_DONE;
      rsp_in.trap_cause = wie_pkg::TC_NONE;

      case (state_ff)
         S_IDLE: begin
            op_in = req_data.operation;
            if (start) begin
               strobe_in = 1'b1;
               case (req_data.operation) inside
                  wie_pkg::OP_UNREACHABLE: begin
                     rsp_in.status     = wie_pkg::ST_TRAP;
                     rsp_in.trap_cause = wie_pkg::TC_UNREACHABLE;
                  end
                  wie_pkg::OP_NOP: ;
                  wie_pkg::OP_CONST: begin
                     if (depth_ff == CW'(wie_pkg::STACK_DEPTH)) begin
                        rsp_in.status = wie_pkg::ST_FALLBACK;
                     end else begin
                        mem_we   = 1'b1;
                        mem_wd   = req_data.immediate;
                        top_in   = req_data.immediate;
                        depth_in = depth_ff + CW'(1);
                     end
                  end
                  wie_pkg::OP_EQZ, wie_pkg::OP_CLZ, wie_pkg::OP_CTZ: begin
                     if (depth_ff == '0) begin
                        rsp_in.status = wie_pkg::ST_FALLBACK;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = PW'(depth_ff - CW'(1));
                        mem_wd = unary;
                        top_in = unary;
                     end
                  end
                  default: begin
                     if (is_bin && depth_ff >= CW'(2)) begin
                        strobe_in = 1'b0;
                        state_in  = S_OPER;
                     end else begin
                        rsp_in.status = wie_pkg::ST_FALLBACK;
                     end
                  end
               endcase
            end
         end
         S_OPER: begin
            mem_ra = PW'(depth_ff - CW'(3));
            if (is_div && rhs == 32'd0) begin
               rsp_in.status     = wie_pkg::ST_TRAP;
               rsp_in.trap_cause = wie_pkg::TC_DIV_ZERO;
               depth_in = depth_ff - CW'(2);
            end else if (op_ff == wie_pkg::OP_DIV_S && lhs == wie_pkg::SIGN_BIT
                         && rhs == wie_pkg::ALL_ONES) begin
               rsp_in.status     = wie_pkg::ST_TRAP;
               rsp_in.trap_cause = wie_pkg::TC_OVERFLOW;
               depth_in = depth_ff - CW'(2);
            end
            if (rsp_in.status == wie_pkg::ST_TRAP) begin
               if (depth_ff == CW'(2)) begin
                  top_in    = 32'd0;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_FETCH;
               end
            end else if (is_div) begin
               div_start = 1'b1;
               state_in  = S_DIV;
               if (op_ff == wie_pkg::OP_DIV_S || op_ff == wie_pkg::OP_REM_S) begin
                  div_a = lhs[31] ? 32'd0 - lhs : lhs;
                  div_b = rhs[31] ? 32'd0 - rhs : rhs;
               end
               if (op_ff == wie_pkg::OP_DIV_S) neg_in = lhs[31] ^ rhs[31];
               else if (op_ff == wie_pkg::OP_REM_S) neg_in = lhs[31];
               else neg_in = 1'b0;
            end else begin
               mem_we    = 1'b1;
               mem_wa    = PW'(depth_ff - CW'(2));
               mem_wd    = alu;
               top_in    = alu;
               depth_in  = depth_ff - CW'(1);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               mem_we    = 1'b1;
               mem_wa    = PW'(depth_ff - CW'(2));
               mem_wd    = dres;
               top_in    = dres;
               depth_in  = depth_ff - CW'(1);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FETCH: begin
            rsp_in.status     = rsp_ff.status;
            rsp_in.trap_cause = rsp_ff.trap_cause;
            top_in    = rd_data_ff;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      rsp_in.stack_top = top_in;
      rsp_in.depth     = 8'(depth_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         depth_ff  <= '0;
         top_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         depth_ff  <= depth_in;
         top_ff    <= top_in;
         strobe_ff <= strobe_in;
      end
      op_ff  <= op_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== design/wie_divider.sv =====
// unsigned 32-bit restoring divider, one quotient bit per cycle
module wie_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic [31:0] rem_ff, quo_ff, div_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff, done_ff;
   logic [32:0] trial;
   logic        fits;

   assign trial = {rem_ff, quo_ff[31]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            quo_ff <= dividend;
            div_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= fits ? 32'(trial - {1'b0, div_ff}) : trial[31:0];
            quo_ff <= {quo_ff[30:0], fits};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench of the wasm i32 stack executor
`timescale 1ns / 100ps

class stack_scoreboard;
   logic [31:0] stack_mem [wie_pkg::STACK_DEPTH];
   int unsigned stack_cnt;
   wie_pkg::rsp_type expected_q[$];
   int unsigned mismatch_cnt;

   function new();
      stack_cnt = 0;
      mismatch_cnt = 0;
   endfunction

   function bit lt_s(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function void note_item(wie_pkg::req_type item);
      wie_pkg::rsp_type r;
      logic [31:0] lhs, rhs, v, res, ma, mb;
      bit push;
      int n;
      r.status = wie_pkg::ST_DONE;
      r.trap_cause = wie_pkg::TC_NONE;
      case (item.operation)
         wie_pkg::OP_UNREACHABLE: begin
            r.status = wie_pkg::ST_TRAP;
            r.trap_cause = wie_pkg::TC_UNREACHABLE;
         end
         wie_pkg::OP_NOP: ;
         wie_pkg::OP_CONST: begin
            if (stack_cnt >= wie_pkg::STACK_DEPTH) r.status = wie_pkg::ST_FALLBACK;
            else begin
               stack_mem[stack_cnt] = item.immediate;
               stack_cnt++;
            end
         end
         wie_pkg::OP_EQZ, wie_pkg::OP_CLZ, wie_pkg::OP_CTZ: begin
            if (stack_cnt == 0) r.status = wie_pkg::ST_FALLBACK;
            else begin
               v = stack_mem[stack_cnt - 1];
               if (item.operation == wie_pkg::OP_EQZ) res = 32'(v == 32'd0);
               else if (item.operation == wie_pkg::OP_CLZ) begin
                  n = 0;
                  while (n < 32 && !v[31 - n]) n++;
                  res = 32'(n);
               end else begin
                  n = 0;
                  while (n < 32 && !v[n]) n++;
                  res = 32'(n);
               end
               stack_mem[stack_cnt - 1] = res;
            end
         end
         default: begin
            if (!((item.operation >= wie_pkg::OP_EQ && item.operation <= wie_pkg::OP_GE_U) ||
                  (item.operation >= wie_pkg::OP_ADD &&
                   item.operation <= wie_pkg::OP_ROTR)))
               r.status = wie_pkg::ST_FALLBACK;
            else if (stack_cnt < 2) r.status = wie_pkg::ST_FALLBACK;
            else begin
               rhs = stack_mem[stack_cnt - 1];
               lhs = stack_mem[stack_cnt - 2];
               stack_cnt -= 2;
               push = 1;
               res = 32'd0;
               case (item.operation)
                  wie_pkg::OP_EQ:   res = 32'(lhs == rhs);
                  wie_pkg::OP_NE:   res = 32'(lhs != rhs);
                  wie_pkg::OP_LT_S: res = 32'(lt_s(lhs, rhs));
                  wie_pkg::OP_LT_U: res = 32'(lhs < rhs);
                  wie_pkg::OP_GT_S: res = 32'(lt_s(rhs, lhs));
                  wie_pkg::OP_GT_U: res = 32'(lhs > rhs);
                  wie_pkg::OP_LE_S: res = 32'(!lt_s(rhs, lhs));
                  wie_pkg::OP_LE_U: res = 32'(lhs <= rhs);
                  wie_pkg::OP_GE_S: res = 32'(!lt_s(lhs, rhs));
                  wie_pkg::OP_GE_U: res = 32'(lhs >= rhs);
                  wie_pkg::OP_ADD:  res = lhs + rhs;
                  wie_pkg::OP_SUB:  res = lhs - rhs;
                  wie_pkg::OP_MUL:  res = lhs * rhs;
                  wie_pkg::OP_DIV_S, wie_pkg::OP_REM_S: begin
                     if (rhs == 32'd0) begin
                        push = 0;
                        r.status = wie_pkg::ST_TRAP;
                        r.trap_cause = wie_pkg::TC_DIV_ZERO;
                     end else if (lhs == wie_pkg::SIGN_BIT && rhs == wie_pkg::ALL_ONES) begin
                        if (item.operation == wie_pkg::OP_DIV_S) begin
                           push = 0;
                           r.status = wie_pkg::ST_TRAP;
                           r.trap_cause = wie_pkg::TC_OVERFLOW;
                        end
                     end else begin
                        ma = lhs[31] ? -lhs : lhs;
                        mb = rhs[31] ? -rhs : rhs;
                        if (item.operation == wie_pkg::OP_DIV_S) begin
                           res = ma / mb;
                           if (lhs[31] ^ rhs[31]) res = -res;
                        end else begin
                           res = ma % mb;
                           if (lhs[31]) res = -res;
                        end
                     end
                  end
                  wie_pkg::OP_DIV_U, wie_pkg::OP_REM_U: begin
                     if (rhs == 32'd0) begin
                        push = 0;
                        r.status = wie_pkg::ST_TRAP;
                        r.trap_cause = wie_pkg::TC_DIV_ZERO;
                     end else if (item.operation == wie_pkg::OP_DIV_U) res = lhs / rhs;
                     else res = lhs % rhs;
                  end
                  wie_pkg::OP_AND:   res = lhs & rhs;
                  wie_pkg::OP_OR:    res = lhs | rhs;
                  wie_pkg::OP_XOR:   res = lhs ^ rhs;
                  wie_pkg::OP_SHL:   res = lhs << rhs[4:0];
                  wie_pkg::OP_SHR_S: res = 32'($signed(lhs) >>> rhs[4:0]);
                  wie_pkg::OP_SHR_U: res = lhs >> rhs[4:0];
                  wie_pkg::OP_ROTL:  res = 32'({lhs, lhs} >> (7'd32 - {2'd0, rhs[4:0]}));
                  default:           res = 32'({lhs, lhs} >> rhs[4:0]);
               endcase
               if (push) begin
                  stack_mem[stack_cnt] = res;
                  stack_cnt++;
               end
            end
         end
      endcase
      r.stack_top = (stack_cnt == 0) ? 32'd0 : stack_mem[stack_cnt - 1];
      r.depth = stack_cnt[7:0];
      expected_q.push_back(r);
   endfunction

   function void check_result(wie_pkg::rsp_type got);
      wie_pkg::rsp_type exp_r;
      if (expected_q.size() == 0) begin
         mismatch_cnt++;
         if (mismatch_cnt <= 10) $display("unexpected result %h", got);
         return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status || got.trap_cause !== exp_r.trap_cause ||
          got.stack_top !== exp_r.stack_top || got.depth !== exp_r.depth) begin
         mismatch_cnt++;
         if (mismatch_cnt <= 10)
            $display({"mismatch: exp st %0d tc %0d top %h dep %0d,",
                      " got st %0d tc %0d top %h dep %0d"},
                     exp_r.status, exp_r.trap_cause, exp_r.stack_top, exp_r.depth,
                     got.status, got.trap_cause, got.stack_top, got.depth);
      end
   endfunction
endclass

module tb_top;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   wie_pkg::req_type req_data;
   logic rsp_strobe;
   wie_pkg::rsp_type rsp_data;
   stack_scoreboard sb;

   wasm_i32_stack_executor dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   localparam logic [7:0] BIN_OPS [25] = '{
      wie_pkg::OP_EQ, wie_pkg::OP_NE, wie_pkg::OP_LT_S, wie_pkg::OP_LT_U,
      wie_pkg::OP_GT_S, wie_pkg::OP_GT_U, wie_pkg::OP_LE_S, wie_pkg::OP_LE_U,
      wie_pkg::OP_GE_S, wie_pkg::OP_GE_U, wie_pkg::OP_ADD, wie_pkg::OP_SUB,
      wie_pkg::OP_MUL, wie_pkg::OP_DIV_S, wie_pkg::OP_DIV_U, wie_pkg::OP_REM_S,
      wie_pkg::OP_REM_U, wie_pkg::OP_AND, wie_pkg::OP_OR, wie_pkg::OP_XOR,
      wie_pkg::OP_SHL, wie_pkg::OP_SHR_S, wie_pkg::OP_SHR_U, wie_pkg::OP_ROTL,
      wie_pkg::OP_ROTR};

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_strobe) sb.check_result(rsp_data);

   // start stays high after the accepting edge; the next falling edge drops it or sets a new item
   task automatic send_item(logic [7:0] op, logic [31:0] imm, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      while (busy) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{operation: op, immediate: imm};
      @(posedge clock);
      sb.note_item('{operation: op, immediate: imm});
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return wie_pkg::ALL_ONES;
         2: return wie_pkg::SIGN_BIT;
         3: return $urandom_range(0, 40);
         4: return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(negedge clock);
   endtask

   initial begin
      int k;
      logic [7:0] op;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send_item(wie_pkg::OP_ADD, 32'd0);
      send_item(wie_pkg::OP_EQZ, 32'd0);
      send_item(wie_pkg::OP_NOP, 32'd0);
      send_item(wie_pkg::OP_UNREACHABLE, 32'd0);
      send_item(8'h05, 32'hFFFF_FFFF);
      send_item(8'hFF, 32'd0);
      send_item(wie_pkg::OP_CONST, wie_pkg::SIGN_BIT);
      send_item(wie_pkg::OP_CONST, wie_pkg::ALL_ONES);
      send_item(wie_pkg::OP_DIV_S, 32'd0);
      send_item(wie_pkg::OP_CONST, wie_pkg::SIGN_BIT);
      send_item(wie_pkg::OP_CONST, wie_pkg::ALL_ONES);
      send_item(wie_pkg::OP_REM_S, 32'd0);
      send_item(wie_pkg::OP_CONST, 32'd0);
      send_item(wie_pkg::OP_DIV_U, 32'd0);
      send_item(wie_pkg::OP_CONST, 32'h7FFF_FFFF);
      send_item(wie_pkg::OP_CLZ, 32'd0);
      send_item(wie_pkg::OP_CTZ, 32'd0);
      send_item(wie_pkg::OP_CONST, 32'd33);
      send_item(wie_pkg::OP_ROTR, 32'd0);
      drain();
      for (k = 0; k < 129; k++) send_item(wie_pkg::OP_CONST, $urandom, 1);
      for (k = 0; k < 130; k++) send_item(BIN_OPS[$urandom_range(0, 24)], 32'd0, k[0]);
      drain();

      // random
      for (k = 0; k < 1620; k++) begin
         case ($urandom_range(0, 19))
            0: op = 8'($urandom);
            1: op = wie_pkg::OP_UNREACHABLE;
            2: op = wie_pkg::OP_NOP;
            3, 4, 5, 6: op = wie_pkg::OP_CONST;
            7: op = wie_pkg::OP_EQZ;
            8: op = wie_pkg::OP_CLZ;
            9: op = wie_pkg::OP_CTZ;
            default: op = BIN_OPS[$urandom_range(0, 24)];
         endcase
         if (sb.stack_cnt < 2 && $urandom_range(0, 3) != 0) op = wie_pkg::OP_CONST;
         send_item(op, (op == wie_pkg::OP_CONST) ? rand_value() : $urandom,
                   $urandom_range(0, 3) == 0);
         if (k == 800) drain();
      end
      drain();
      if (sb.mismatch_cnt == 0 && sb.expected_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
